// ===== hw/rtl/md5_pkg.sv =====
package md5_pkg;

  // Chaining values loaded at reset and after each digest
  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;

  // Padding marker and block layout
  localparam logic [7:0]  PAD_BYTE    = 8'h80;
  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned LEN_POS     = 56;
  localparam int unsigned WORD_BYTES  = 4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INSERT,
    ST_PAD_MARK,
    ST_PAD_TAIL,
    ST_INIT,
    ST_ROUND,
    ST_FOLD,
    ST_DONE
  } state_t;

  // Where to go once a compression finishes
  typedef enum logic [1:0] {
    RET_INSERT,
    RET_TAIL,
    RET_DONE
  } ret_t;

  typedef struct packed {
    logic load;
    logic insert;
    logic pad_mark;
    logic pad_tail;
    logic init;
    logic round;
    logic fold;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic full_after;
    logic rest_zero;
    logic last;
    logic fits;
    logic round_last;
    logic out_free;
  } stat_t;

  // Per-round additive constants
  function automatic logic [31:0] sine_const(input logic [5:0] i);
    logic [31:0] k;
    begin
      unique case (i)
        6'd0:  k = 32'hd76aa478;
        6'd1:  k = 32'he8c7b756;
        6'd2:  k = 32'h242070db;
        6'd3:  k = 32'hc1bdceee;
        6'd4:  k = 32'hf57c0faf;
        6'd5:  k = 32'h4787c62a;
        6'd6:  k = 32'ha8304613;
        6'd7:  k = 32'hfd469501;
        6'd8:  k = 32'h698098d8;
        6'd9:  k = 32'h8b44f7af;
        6'd10: k = 32'hffff5bb1;
        6'd11: k = 32'h895cd7be;
        6'd12: k = 32'h6b901122;
        6'd13: k = 32'hfd987193;
        6'd14: k = 32'ha679438e;
        6'd15: k = 32'h49b40821;
        6'd16: k = 32'hf61e2562;
        6'd17: k = 32'hc040b340;
        6'd18: k = 32'h265e5a51;
        6'd19: k = 32'he9b6c7aa;
        6'd20: k = 32'hd62f105d;
        6'd21: k = 32'h02441453;
        6'd22: k = 32'hd8a1e681;
        6'd23: k = 32'he7d3fbc8;
        6'd24: k = 32'h21e1cde6;
        6'd25: k = 32'hc33707d6;
        6'd26: k = 32'hf4d50d87;
        6'd27: k = 32'h455a14ed;
        6'd28: k = 32'ha9e3e905;
        6'd29: k = 32'hfcefa3f8;
        6'd30: k = 32'h676f02d9;
        6'd31: k = 32'h8d2a4c8a;
        6'd32: k = 32'hfffa3942;
        6'd33: k = 32'h8771f681;
        6'd34: k = 32'h6d9d6122;
        6'd35: k = 32'hfde5380c;
        6'd36: k = 32'ha4beea44;
        6'd37: k = 32'h4bdecfa9;
        6'd38: k = 32'hf6bb4b60;
        6'd39: k = 32'hbebfbc70;
        6'd40: k = 32'h289b7ec6;
        6'd41: k = 32'heaa127fa;
        6'd42: k = 32'hd4ef3085;
        6'd43: k = 32'h04881d05;
        6'd44: k = 32'hd9d4d039;
        6'd45: k = 32'he6db99e5;
        6'd46: k = 32'h1fa27cf8;
        6'd47: k = 32'hc4ac5665;
        6'd48: k = 32'hf4292244;
        6'd49: k = 32'h432aff97;
        6'd50: k = 32'hab9423a7;
        6'd51: k = 32'hfc93a039;
        6'd52: k = 32'h655b59c3;
        6'd53: k = 32'h8f0ccc92;
        6'd54: k = 32'hffeff47d;
        6'd55: k = 32'h85845dd1;
        6'd56: k = 32'h6fa87e4f;
        6'd57: k = 32'hfe2ce6e0;
        6'd58: k = 32'ha3014314;
        6'd59: k = 32'h4e0811a1;
        6'd60: k = 32'hf7537e82;
        6'd61: k = 32'hbd3af235;
        6'd62: k = 32'h2ad7d2bb;
        6'd63: k = 32'heb86d391;
        default: k = 32'h0;
      endcase
      return k;
    end
  endfunction

  // Left-rotate amount by stage and round position within a group of four
  function automatic logic [4:0] rot_amount(input logic [1:0] stage, input logic [1:0] j);
    logic [4:0] s;
    begin
      unique case ({stage, j})
        4'h0: s = 5'd7;
        4'h1: s = 5'd12;
        4'h2: s = 5'd17;
        4'h3: s = 5'd22;
        4'h4: s = 5'd5;
        4'h5: s = 5'd9;
        4'h6: s = 5'd14;
        4'h7: s = 5'd20;
        4'h8: s = 5'd4;
        4'h9: s = 5'd11;
        4'ha: s = 5'd16;
        4'hb: s = 5'd23;
        4'hc: s = 5'd6;
        4'hd: s = 5'd10;
        4'he: s = 5'd15;
        4'hf: s = 5'd21;
        default: s = 5'd0;
      endcase
      return s;
    end
  endfunction

endpackage

// ===== hw/rtl/md5_datapath.sv =====
module md5_datapath (
  input  logic                clk,
  input  logic                rst,
  input  md5_pkg::cmd_t       cmd,
  output md5_pkg::stat_t      stat,
  input  logic [31:0]         data_word,
  input  logic [2:0]          valid_bytes,
  input  logic                last_word,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [63:0]         digest_ab,
  output logic [63:0]         digest_cd
);

  localparam logic [6:0] BlockBytes = 7'(md5_pkg::BLOCK_BYTES);
  localparam logic [6:0] LenPos     = 7'(md5_pkg::LEN_POS);
  localparam logic [2:0] WordBytes  = 3'(md5_pkg::WORD_BYTES);
  localparam int         BlockWords = md5_pkg::BLOCK_BYTES / md5_pkg::WORD_BYTES;

  logic [31:0] word_reg;
  logic [2:0]  rem;
  logic        last_reg;
  logic [63:0] len;
  logic [6:0]  fill;
  logic [31:0] blk [BlockWords];

  logic [md5_pkg::BLOCK_BYTES-1:0]   lane_en;
  logic [8*md5_pkg::BLOCK_BYTES-1:0] lane_data;

  logic [31:0] chain_a, chain_b, chain_c, chain_d;
  logic [31:0] wa, wb, wc, wd;
  logic [5:0]  round;

  logic [2:0]  count;
  logic [6:0]  space;
  logic [2:0]  n;
  logic [6:0]  fill_after;

  // Clamp the byte count and size the next insertion to the room left
  assign count      = (valid_bytes > WordBytes) ? WordBytes : valid_bytes;
  assign space      = BlockBytes - fill;
  assign n          = ({4'b0, rem} < space) ? rem : space[2:0];
  assign fill_after = fill + {4'b0, n};

  assign stat.full_after = (fill_after == BlockBytes);
  assign stat.rest_zero  = (rem == n);
  assign stat.last       = last_reg;
  assign stat.fits       = (fill < LenPos);
  assign stat.round_last = (round == 6'd63);
  assign stat.out_free   = !out_valid || !out_stall;

  // Byte lanes of the block buffer
  for (genvar p = 0; p < md5_pkg::BLOCK_BYTES; p++) begin : g_byte
    localparam logic [6:0] Pos = 7'(p);
    logic [7:0] len_byte;
    logic [6:0] off;
    logic       wr_en;
    logic [7:0] wr_data;

    if (p >= md5_pkg::LEN_POS) begin : g_len
      assign len_byte = len[8*(p-md5_pkg::LEN_POS) +: 8];
    end else begin : g_nolen
      assign len_byte = 8'h00;
    end

    assign off = Pos - fill;

    // Select what lands in this byte
    always_comb begin
      wr_en   = 1'b0;
      wr_data = 8'h00;
      if (cmd.insert) begin
        if (Pos >= fill && off < {4'b0, n}) begin
          wr_en   = 1'b1;
          wr_data = word_reg[{off[1:0], 3'b000} +: 8];
        end
      end else if (cmd.pad_mark) begin
        if (Pos == fill) begin
          wr_en   = 1'b1;
          wr_data = md5_pkg::PAD_BYTE;
        end else if (Pos > fill) begin
          wr_en   = 1'b1;
          wr_data = stat.fits ? len_byte : 8'h00;
        end
      end else if (cmd.pad_tail) begin
        wr_en   = 1'b1;
        wr_data = len_byte;
      end
    end

    assign lane_en[p]           = wr_en;
    assign lane_data[8*p +: 8]  = wr_data;
  end

  // Write the buffer words under their byte enables
  always_ff @(posedge clk) begin
    for (int w = 0; w < BlockWords; w++) begin
      for (int b = 0; b < md5_pkg::WORD_BYTES; b++) begin
        if (lane_en[md5_pkg::WORD_BYTES*w + b]) begin
          blk[w][8*b +: 8] <= lane_data[32*w + 8*b +: 8];
        end
      end
    end
  end

  // Round function
  logic [1:0]  stage;
  logic [3:0]  gidx;
  logic [31:0] f;
  logic [31:0] m;
  logic [31:0] t;
  logic [63:0] rot_full;
  logic [31:0] nb;

  assign stage = round[5:4];

  always_comb begin
    case (stage)
      2'd0: begin
        f    = (wb & wc) | (~wb & wd);
        gidx = round[3:0];
      end
      2'd1: begin
        f    = (wb & wd) | (wc & ~wd);
        gidx = round[3:0] * 4'd5 + 4'd1;
      end
      2'd2: begin
        f    = wb ^ wc ^ wd;
        gidx = round[3:0] * 4'd3 + 4'd5;
      end
      default: begin
        f    = wc ^ (wb | ~wd);
        gidx = round[3:0] * 4'd7;
      end
    endcase
  end

  assign m        = blk[gidx];
  assign t        = wa + f + m + md5_pkg::sine_const(round);
  assign rot_full = {t, t} << md5_pkg::rot_amount(stage, round[1:0]);
  assign nb       = wb + rot_full[63:32];

  // Length and fill counters and chaining state
  always_ff @(posedge clk) begin
    if (rst) begin
      len     <= '0;
      fill    <= '0;
      chain_a <= md5_pkg::INIT_A;
      chain_b <= md5_pkg::INIT_B;
      chain_c <= md5_pkg::INIT_C;
      chain_d <= md5_pkg::INIT_D;
    end else begin
      if (cmd.load) begin
        len <= len + {58'b0, count, 3'b000};
      end
      if (cmd.insert) begin
        fill <= fill_after;
      end
      if (cmd.fold) begin
        fill    <= '0;
        chain_a <= chain_a + wa;
        chain_b <= chain_b + wb;
        chain_c <= chain_c + wc;
        chain_d <= chain_d + wd;
      end
      if (cmd.emit) begin
        len     <= '0;
        fill    <= '0;
        chain_a <= md5_pkg::INIT_A;
        chain_b <= md5_pkg::INIT_B;
        chain_c <= md5_pkg::INIT_C;
        chain_d <= md5_pkg::INIT_D;
      end
    end
  end

  // Hold the word under insertion
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      word_reg <= data_word;
      rem      <= count;
      last_reg <= last_word;
    end else if (cmd.insert) begin
      word_reg <= word_reg >> {n, 3'b000};
      rem      <= rem - n;
    end
  end

  // Working variables of the compression
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      wa    <= chain_a;
      wb    <= chain_b;
      wc    <= chain_c;
      wd    <= chain_d;
      round <= '0;
    end else if (cmd.round) begin
      wa    <= wd;
      wd    <= wc;
      wc    <= wb;
      wb    <= nb;
      round <= round + 6'd1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      digest_ab <= {chain_b, chain_a};
      digest_cd <= {chain_d, chain_c};
    end
  end

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("digest not presented after emit");

  a_emit_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || !out_stall))
    else $error("emit overwrote a waiting digest");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= BlockBytes)
    else $error("block fill beyond 64 bytes");

endmodule

// ===== hw/rtl/md5_ctrl.sv =====
module md5_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  md5_pkg::stat_t stat,
  output md5_pkg::cmd_t  cmd
);

  md5_pkg::state_t state, state_next;
  md5_pkg::ret_t   ret, ret_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= md5_pkg::ST_IDLE;
      ret   <= md5_pkg::RET_INSERT;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  // Advance the sequencer
  always_comb begin
    state_next = state;
    ret_next   = ret;
    unique case (state)
      md5_pkg::ST_IDLE: begin
        if (in_valid) state_next = md5_pkg::ST_INSERT;
      end
      md5_pkg::ST_INSERT: begin
        if (stat.full_after) begin
          state_next = md5_pkg::ST_INIT;
          ret_next   = md5_pkg::RET_INSERT;
        end else if (stat.rest_zero) begin
          state_next = stat.last ? md5_pkg::ST_PAD_MARK : md5_pkg::ST_IDLE;
        end
      end
      md5_pkg::ST_PAD_MARK: begin
        state_next = md5_pkg::ST_INIT;
        ret_next   = stat.fits ? md5_pkg::RET_DONE : md5_pkg::RET_TAIL;
      end
      md5_pkg::ST_PAD_TAIL: begin
        state_next = md5_pkg::ST_INIT;
        ret_next   = md5_pkg::RET_DONE;
      end
      md5_pkg::ST_INIT: begin
        state_next = md5_pkg::ST_ROUND;
      end
      md5_pkg::ST_ROUND: begin
        if (stat.round_last) state_next = md5_pkg::ST_FOLD;
      end
      md5_pkg::ST_FOLD: begin
        unique case (ret)
          md5_pkg::RET_INSERT: state_next = md5_pkg::ST_INSERT;
          md5_pkg::RET_TAIL:   state_next = md5_pkg::ST_PAD_TAIL;
          md5_pkg::RET_DONE:   state_next = md5_pkg::ST_DONE;
          default:             state_next = md5_pkg::ST_IDLE;
        endcase
      end
      md5_pkg::ST_DONE: begin
        if (stat.out_free) state_next = md5_pkg::ST_IDLE;
      end
      default: state_next = md5_pkg::ST_IDLE;
    endcase
  end

  // Drive datapath commands
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      md5_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      md5_pkg::ST_INSERT:   cmd.insert   = 1'b1;
      md5_pkg::ST_PAD_MARK: cmd.pad_mark = 1'b1;
      md5_pkg::ST_PAD_TAIL: cmd.pad_tail = 1'b1;
      md5_pkg::ST_INIT:     cmd.init     = 1'b1;
      md5_pkg::ST_ROUND:    cmd.round    = 1'b1;
      md5_pkg::ST_FOLD:     cmd.fold     = 1'b1;
      md5_pkg::ST_DONE:     cmd.emit     = stat.out_free;
      default: ;
    endcase
  end

  a_round_exit: assert property (@(posedge clk) disable iff (rst)
    state == md5_pkg::ST_ROUND |=> (state == md5_pkg::ST_ROUND || state == md5_pkg::ST_FOLD))
    else $error("round sequence left early");

  a_final_fold: assert property (@(posedge clk) disable iff (rst)
    (state == md5_pkg::ST_FOLD && ret == md5_pkg::RET_DONE) |=> state == md5_pkg::ST_DONE)
    else $error("final compression did not lead to digest");

  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    (state == md5_pkg::ST_DONE && !stat.out_free) |=> state == md5_pkg::ST_DONE)
    else $error("digest dropped while output busy");

endmodule

// ===== hw/rtl/md5_message_digest_top.sv =====
// Channel  Handshake            Fields
// in       in_valid / in_stall  data_word[31:0], valid_bytes[2:0], last_word
// out      out_valid/ out_stall digest_ab[63:0], digest_cd[63:0]
//
// A word is accepted, then inserted; each full 64-byte block adds a compression
// (start, 64 rounds, fold, resume insert) through the single round unit.
// A last word adds the pad step, one or two compressions and the emit step.
// Reset (rst, synchronous) restores the chaining values and clears length and fill.
// A waiting digest holds in the output register; a new digest waits behind it.
module md5_message_digest_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] data_word,
  input  logic [2:0]  valid_bytes,
  input  logic        last_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] digest_ab,
  output logic [63:0] digest_cd
);

  md5_pkg::cmd_t  cmd;
  md5_pkg::stat_t stat;

  md5_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  md5_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .data_word   (data_word),
    .valid_bytes (valid_bytes),
    .last_word   (last_word),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .digest_ab   (digest_ab),
    .digest_cd   (digest_cd)
  );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned PHASE_WORDS  = 155;

  // Additive constant per round
  localparam logic [31:0] SINE_K [0:63] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Rotate amount, indexed by stage * 4 + round within group
  localparam int unsigned ROT_AMT [0:15] = '{
    7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
  };

  // Message lengths in bytes that sit on or near block and padding edges
  localparam int unsigned EDGE_LEN [0:11] = '{
    0, 1, 3, 4, 55, 56, 57, 63, 64, 65, 119, 120
  };

  typedef struct {
    logic [63:0] ab;
    logic [63:0] cd;
  } digest_t;

  class md5_scoreboard;
    logic [31:0]  hash_a, hash_b, hash_c, hash_d;
    logic [31:0]  blk [16];
    int unsigned  fill;
    logic [63:0]  bit_len;
    digest_t      digests_due [$];
    int unsigned  errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      hash_a  = md5_pkg::INIT_A;
      hash_b  = md5_pkg::INIT_B;
      hash_c  = md5_pkg::INIT_C;
      hash_d  = md5_pkg::INIT_D;
      fill    = 0;
      bit_len = '0;
      foreach (blk[i]) blk[i] = '0;
    endfunction

    function logic [31:0] rol(logic [31:0] x, int unsigned s);
      return (x << s) | (x >> (32 - s));
    endfunction

    // Run the 64 rounds over the buffered block and fold into the chain
    function void compress_block();
      logic [31:0] a, b, c, d, f, t;
      int unsigned g, stg;
      a = hash_a;
      b = hash_b;
      c = hash_c;
      d = hash_d;
      for (int i = 0; i < 64; i++) begin
        stg = i / 16;
        case (stg)
          0: begin
            f = (b & c) | (~b & d);
            g = i;
          end
          1: begin
            f = (b & d) | (c & ~d);
            g = (5 * i + 1) % 16;
          end
          2: begin
            f = b ^ c ^ d;
            g = (3 * i + 5) % 16;
          end
          default: begin
            f = c ^ (b | ~d);
            g = (7 * i) % 16;
          end
        endcase
        t = a + f + blk[g] + SINE_K[i];
        a = d;
        d = c;
        c = b;
        b = b + rol(t, ROT_AMT[stg * 4 + i % 4]);
      end
      hash_a += a;
      hash_b += b;
      hash_c += c;
      hash_d += d;
    endfunction

    function void absorb_byte(logic [7:0] bt);
      blk[fill / 4][(fill % 4) * 8 +: 8] = bt;
      fill++;
      if (fill == md5_pkg::BLOCK_BYTES) begin
        compress_block();
        fill = 0;
      end
    endfunction

    // Take an accepted word; on the last word pad and queue the digest
    function void note_word(logic [31:0] w, logic [2:0] nb, logic lst);
      int unsigned cnt;
      logic [63:0] msg_bits;
      digest_t dg;
      cnt = (nb > 3'd4) ? 4 : int'(nb);
      for (int k = 0; k < cnt; k++) begin
        absorb_byte(w[8 * k +: 8]);
        bit_len += 64'd8;
      end
      if (lst) begin
        msg_bits = bit_len;
        absorb_byte(md5_pkg::PAD_BYTE);
        while (fill != md5_pkg::LEN_POS) absorb_byte(8'h00);
        for (int k = 0; k < 8; k++) absorb_byte(msg_bits[8 * k +: 8]);
        dg.ab = {hash_b, hash_a};
        dg.cd = {hash_d, hash_c};
        digests_due.push_back(dg);
        restart();
      end
    endfunction

    function void check_digest(logic [63:0] ab, logic [63:0] cd);
      digest_t want;
      if (digests_due.size() == 0) begin
        if (errors < 10)
          $display("[%0t] digest with none due: ab=%h cd=%h", $realtime, ab, cd);
        errors++;
      end else begin
        want = digests_due.pop_front();
        if (ab !== want.ab) begin
          if (errors < 10)
            $display("[%0t] digest_ab exp=%h got=%h", $realtime, want.ab, ab);
          errors++;
        end
        if (cd !== want.cd) begin
          if (errors < 10)
            $display("[%0t] digest_cd exp=%h got=%h", $realtime, want.cd, cd);
          errors++;
        end
      end
    endfunction

    function int unsigned pending();
      return digests_due.size();
    endfunction
  endclass

  logic        clk;
  logic        rst         = 1'b1;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  logic [31:0] data_word   = '0;
  logic [2:0]  valid_bytes = '0;
  logic        last_word   = 1'b0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  logic [63:0] digest_ab;
  logic [63:0] digest_cd;

  md5_scoreboard sb = new();
  int unsigned   src_idle   = 0;
  int unsigned   rcv_idle   = 0;
  int unsigned   words_sent = 0;
  int unsigned   cycle_cnt  = 0;

  md5_message_digest_top u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_word   (data_word),
    .valid_bytes (valid_bytes),
    .last_word   (last_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .digest_ab   (digest_ab),
    .digest_cd   (digest_cd)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Check accepted digests, then pick the next stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_digest(digest_ab, digest_cd);
    out_stall <= ($urandom_range(0, 99) < rcv_idle);
  end

  // Offer one word, idling first at random; hold it until taken
  task automatic push_word(input logic [31:0] w, input logic [2:0] nb, input logic lst);
    while ($urandom_range(0, 99) < src_idle) begin
      in_valid  <= 1'b0;
      data_word <= $urandom;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    data_word   <= w;
    valid_bytes <= nb;
    last_word   <= lst;
    do @(posedge clk); while (in_stall);
    sb.note_word(w, nb, lst);
    words_sent++;
  endtask

  // Well-formed message: full words, then a last word of zero to four bytes
  task automatic send_message(input int unsigned nbytes);
    int unsigned rem;
    bit empty_tail;
    rem = nbytes;
    empty_tail = $urandom_range(0, 1);
    while (rem > 4 || (rem == 4 && empty_tail)) begin
      push_word($urandom, 3'd4, 1'b0);
      rem -= 4;
    end
    push_word($urandom, 3'(rem), 1'b1);
  endtask

  // Ragged message: any byte count on any word, counts above four included
  task automatic send_ragged();
    int unsigned nw;
    nw = $urandom_range(1, 24);
    for (int i = 0; i < nw - 1; i++)
      push_word($urandom, 3'($urandom_range(0, 7)), 1'b0);
    push_word($urandom, 3'($urandom_range(0, 7)), 1'b1);
  endtask

  // Hold the input until every digest is back and the block has settled
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int unsigned s_idle, input int unsigned r_idle);
    int unsigned stop_at, sel;
    src_idle = s_idle;
    rcv_idle = r_idle;
    stop_at = words_sent + PHASE_WORDS;
    while (words_sent < stop_at) begin
      sel = $urandom_range(0, 99);
      if (sel < 12)
        send_ragged();
      else if (sel < 40)
        send_message(EDGE_LEN[$urandom_range(0, 11)]);
      else if (sel < 92)
        send_message($urandom_range(0, 64));
      else
        send_message($urandom_range(65, 260));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty message, short messages, extreme bytes, byte packing
    push_word(32'hffffffff, 3'd0, 1'b1);
    push_word(32'h00636261, 3'd3, 1'b1);
    push_word(32'hffffffff, 3'd4, 1'b1);
    push_word(32'h00000000, 3'd4, 1'b1);
    push_word(32'h00000000, 3'd7, 1'b1);
    push_word(32'hffffff5a, 3'd1, 1'b0);
    push_word(32'h0000a5c3, 3'd2, 1'b0);
    push_word(32'h87654321, 3'd5, 1'b0);
    push_word(32'hdeadbeef, 3'd6, 1'b1);
    // 56 bytes: padding spills into a second block
    for (int i = 0; i < 13; i++) push_word($urandom, 3'd4, 1'b0);
    push_word(32'hffffffff, 3'd4, 1'b1);
    wait_drained();

    run_phase(35, 46);
    wait_drained();
    run_phase(46, 35);
    run_phase(0, 0);

    wait_drained();
    if (sb.errors == 0 && sb.pending() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/md5_pkg.sv
hw/rtl/md5_datapath.sv
hw/rtl/md5_ctrl.sv
hw/rtl/md5_message_digest_top.sv
sim/tb_top.sv
